@@ rtl/core/cacp_pkg.sv @@
// Shared types and constants of the clipped autocorrelation peak core.
package cacp_pkg;

   // Defaults for the top-level parameters.
   localparam int FRAME_MAX_DEF   = 512;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths.
   localparam int FRAME_LEN_W = 10;
   localparam int LAG_W       = 9;
   localparam int SCALE_W     = 8;
   localparam int PEAK_W      = 11;
   localparam int ZLC_W       = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // Register reset values.
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST  = 10'd320;
   localparam logic [LAG_W-1:0]       MIN_LAG_RST    = 9'd20;
   localparam logic [LAG_W-1:0]       MAX_LAG_RST    = 9'd200;
   localparam logic [SCALE_W-1:0]     CLIP_SCALE_RST = 8'd174;

   // Smallest frame length that is used.
   localparam int FRAME_MIN = 3;

   // floor(x / 3) == (x * RECIP_THIRD) >> THIRD_SHIFT for x below 2**17.
   localparam logic [31:0] RECIP_THIRD = 32'd43691;
   localparam int          THIRD_SHIFT = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_LENGTH = 2'd0,
      CSR_MIN_LAG      = 2'd1,
      CSR_MAX_LAG      = 2'd2,
      CSR_CLIP_SCALE   = 2'd3
   } csr_index_type;

   // Center-clipped sample codes.
   localparam logic [1:0] CLIP_ZERO = 2'b00;
   localparam logic [1:0] CLIP_POS  = 2'b01;
   localparam logic [1:0] CLIP_NEG  = 2'b11;

   typedef struct packed {
      logic [LAG_W-1:0]   lag_lo;
      logic [LAG_W-1:0]   lag_hi;
      logic [SCALE_W-1:0] clip_scale;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_DONE,
      ST_MULT,
      ST_CLIP,
      ST_CLIP_DONE,
      ST_LAG_START,
      ST_LAG_RUN,
      ST_LAG_DRAIN,
      ST_LAG_END,
      ST_PUBLISH
   } state_type;

endpackage

@@ rtl/core/cacp_sample_ram.sv @@
// Sample store: one write port and one registered read port.
module cacp_sample_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cacp_clip_ram.sv @@
// Clipped sample store: one write port and two registered read ports.
module cacp_clip_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [1:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [1:0]        rd_data_a,
   output logic [1:0]        rd_data_b
);

   logic [1:0] store_ff [DEPTH];
   logic [1:0] rd_a_ff;
   logic [1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/cacp_engine.sv @@
// Sequencer and shared datapath: frame load, peak scan, clipping and lag search.
module cacp_engine #(
   parameter int FRAME_MAX   = 512,
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_W       = 10,
   parameter int ADDR_W      = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CNT_W-1:0]                 frame_len,
   input  cacp_pkg::cfg_type                cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [cacp_pkg::PEAK_W-1:0] rsp_peak_value,
   output logic [cacp_pkg::LAG_W-1:0]       rsp_peak_lag,
   output logic [cacp_pkg::ZLC_W-1:0]       rsp_zero_lag_count,
   output logic signed [SAMPLE_BITS-1:0]    rsp_clip_level,
   output logic                             sram_we,
   output logic [ADDR_W-1:0]                sram_waddr,
   output logic [SAMPLE_BITS-1:0]           sram_wdata,
   output logic [ADDR_W-1:0]                sram_raddr,
   input  logic [SAMPLE_BITS-1:0]           sram_rdata,
   output logic                             cram_we,
   output logic [ADDR_W-1:0]                cram_waddr,
   output logic [1:0]                       cram_wdata,
   output logic [ADDR_W-1:0]                cram_raddr_a,
   output logic [ADDR_W-1:0]                cram_raddr_b,
   input  logic [1:0]                       cram_rdata_a,
   input  logic [1:0]                       cram_rdata_b
);

   import cacp_pkg::*;

   localparam int SUM_W  = CNT_W + 1;
   localparam int LW     = (CNT_W > LAG_W) ? CNT_W : LAG_W;
   localparam int PROD_W = SAMPLE_BITS + SCALE_W + 1;
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic              scan_vld_ff, scan_vld_in;
   logic              clip_vld_ff, clip_vld_in;
   logic              corr_vld_ff, corr_vld_in;
   logic [CNT_W-1:0]  third_ff, third_in;
   logic [CNT_W-1:0]  two_third_ff, two_third_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic [CNT_W-1:0]  nonzero_ff, nonzero_in;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic signed [SUM_W-1:0] lag_sum_ff, lag_sum_in;
   logic signed [SUM_W-1:0] best_sum_ff, best_sum_in;
   logic [LAG_W-1:0]  best_lag_ff, best_lag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [PEAK_W-1:0]      out_peak_ff, out_peak_in;
   logic [LAG_W-1:0]              out_lag_ff, out_lag_in;
   logic [ZLC_W-1:0]              out_count_ff, out_count_in;
   logic signed [SAMPLE_BITS-1:0] out_level_ff, out_level_in;

   logic [CNT_W-1:0]  count_next;
   logic [CNT_W-1:0]  n_last;
   logic              idx_last;
   logic [LW:0]       pair_sum;
   logic              lag_beyond;
   logic signed [SAMPLE_BITS-1:0] rd_sample;
   logic signed [SAMPLE_BITS-1:0] min_peak;
   logic signed [SAMPLE_BITS-1:0] thr;
   logic signed [SAMPLE_BITS:0]   sample_ext;
   logic signed [SAMPLE_BITS:0]   thr_ext;
   logic signed [SAMPLE_BITS:0]   neg_thr;
   logic [1:0]        clip_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         clip_vld_ff  <= 1'b0;
         corr_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= MOST_NEG;
         right_ff     <= MOST_NEG;
         lag_sum_ff   <= '0;
         best_sum_ff  <= '0;
         best_lag_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_vld_ff  <= scan_vld_in;
         clip_vld_ff  <= clip_vld_in;
         corr_vld_ff  <= corr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         lag_sum_ff   <= lag_sum_in;
         best_sum_ff  <= best_sum_in;
         best_lag_ff  <= best_lag_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      third_ff     <= third_in;
      two_third_ff <= two_third_in;
      prod_ff      <= prod_in;
      nonzero_ff   <= nonzero_in;
      lag_ff       <= lag_in;
      out_peak_ff  <= out_peak_in;
      out_lag_ff   <= out_lag_in;
      out_count_ff <= out_count_in;
      out_level_ff <= out_level_in;
   end

   assign count_next = count_ff + 1'b1;
   assign n_last     = frame_len - 1'b1;
   assign idx_last   = (CNT_W'(idx_ff) == n_last);
   assign pair_sum   = (LW+1)'(idx_ff) + (LW+1)'(lag_ff);
   assign lag_beyond = ((LW+1)'(lag_ff) >= (LW+1)'(frame_len));

   assign rd_sample  = $signed(sram_rdata);
   assign min_peak   = (left_ff < right_ff) ? left_ff : right_ff;
   // The arithmetic shift by eight floors the Q8 product.
   assign thr        = $signed(prod_ff[SAMPLE_BITS+SCALE_W-1:SCALE_W]);
   assign sample_ext = (SAMPLE_BITS+1)'(rd_sample);
   assign thr_ext    = (SAMPLE_BITS+1)'(thr);
   assign neg_thr    = -thr_ext;

   // A negative threshold lets the positive test win.
   always_comb begin
      if (sample_ext > thr_ext) begin
         clip_code = CLIP_POS;
      end else if (sample_ext < neg_thr) begin
         clip_code = CLIP_NEG;
      end else begin
         clip_code = CLIP_ZERO;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_idx_in    = idx_ff;
      scan_vld_in  = 1'b0;
      clip_vld_in  = 1'b0;
      corr_vld_in  = 1'b0;
      third_in     = third_ff;
      two_third_in = two_third_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      prod_in      = prod_ff;
      nonzero_in   = nonzero_ff;
      lag_in       = lag_ff;
      lag_sum_in   = lag_sum_ff;
      best_sum_in  = best_sum_ff;
      best_lag_in  = best_lag_ff;
      rsp_valid_in = rsp_valid_ff;
      out_peak_in  = out_peak_ff;
      out_lag_in   = out_lag_ff;
      out_count_in = out_count_ff;
      out_level_in = out_level_ff;

      req_ready    = 1'b0;
      sram_we      = 1'b0;
      sram_waddr   = count_ff[ADDR_W-1:0];
      sram_wdata   = req_sample;
      sram_raddr   = idx_ff;
      cram_we      = 1'b0;
      cram_waddr   = rd_idx_ff;
      cram_wdata   = clip_code;
      cram_raddr_a = idx_ff;
      cram_raddr_b = pair_sum[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Read data returns in the cycle after the address was issued.
      if (scan_vld_ff) begin
         if (CNT_W'(rd_idx_ff) < third_ff && rd_sample > left_ff) begin
            left_in = rd_sample;
         end
         if (CNT_W'(rd_idx_ff) >= two_third_ff && rd_sample > right_ff) begin
            right_in = rd_sample;
         end
      end

      if (clip_vld_ff) begin
         cram_we = 1'b1;
         if (clip_code != CLIP_ZERO) begin
            nonzero_in = nonzero_ff + 1'b1;
         end
      end

      if (corr_vld_ff && cram_rdata_a != CLIP_ZERO && cram_rdata_b != CLIP_ZERO) begin
         if (cram_rdata_a == cram_rdata_b) begin
            lag_sum_in = lag_sum_ff + SUM_W'(1);
         end else begin
            lag_sum_in = lag_sum_ff - SUM_W'(1);
         end
      end

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sram_we = (count_ff < CNT_W'(FRAME_MAX));
               if (count_next >= frame_len) begin
                  count_in     = '0;
                  idx_in       = '0;
                  left_in      = MOST_NEG;
                  right_in     = MOST_NEG;
                  third_in     = CNT_W'((32'(frame_len) * RECIP_THIRD) >> THIRD_SHIFT);
                  two_third_in =
                     CNT_W'(((32'(frame_len) << 1) * RECIP_THIRD) >> THIRD_SHIFT);
                  state_in     = ST_SCAN;
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_SCAN: begin
            scan_vld_in = 1'b1;
            if (idx_last) begin
               state_in = ST_SCAN_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN_DONE: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in    = min_peak * $signed({1'b0, cfg.clip_scale});
            nonzero_in = '0;
            idx_in     = '0;
            state_in   = ST_CLIP;
         end
         ST_CLIP: begin
            clip_vld_in = 1'b1;
            if (idx_last) begin
               state_in = ST_CLIP_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CLIP_DONE: begin
            lag_in   = cfg.lag_lo;
            state_in = ST_LAG_START;
         end
         ST_LAG_START: begin
            lag_sum_in = '0;
            idx_in     = '0;
            // A lag at or beyond the frame length has no pairs and sums to zero.
            if (lag_beyond) begin
               state_in = ST_LAG_END;
            end else begin
               state_in = ST_LAG_RUN;
            end
         end
         ST_LAG_RUN: begin
            corr_vld_in = 1'b1;
            if (pair_sum == (LW+1)'(n_last)) begin
               state_in = ST_LAG_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAG_DRAIN: begin
            state_in = ST_LAG_END;
         end
         ST_LAG_END: begin
            if (lag_ff == cfg.lag_lo || lag_sum_ff > best_sum_ff) begin
               best_sum_in = lag_sum_ff;
               best_lag_in = lag_ff;
            end
            if (lag_ff == cfg.lag_hi) begin
               state_in = ST_PUBLISH;
            end else begin
               lag_in   = lag_ff + 1'b1;
               state_in = ST_LAG_START;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_peak_in  = PEAK_W'(best_sum_ff);
               out_lag_in   = best_lag_ff;
               out_count_in = ZLC_W'(nonzero_ff);
               out_level_in = thr;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak_value     = out_peak_ff;
   assign rsp_peak_lag       = out_lag_ff;
   assign rsp_zero_lag_count = out_count_ff;
   assign rsp_clip_level     = out_level_ff;

endmodule

@@ rtl/core/clipped_autocorrelation_peak_core.sv @@
// Top level of the clipped autocorrelation peak core: registers, stores and engine.
//
//   Channel   Ports                                   Moves
//   req       req_valid/req_ready, req_sample         one sample per transaction
//   rsp       rsp_valid/rsp_ready, rsp_peak_*, ...    one result per frame
//   csr       csr_wen, csr_index, csr_wdata           register write, no wait
//
// A sample that does not end the frame is taken with req_ready high. The frame's last sample
// starts a pass for peaks and clipping, then a search over each lag k, one clipped pair per
// cycle (a lag k >= n has no pairs), and the result then goes to an output register; req_ready
// is low throughout. The next frame loads while that result waits; a finished frame stalls
// until the register is free.
// Reset is synchronous; the stores keep their contents and need no clearing.
module clipped_autocorrelation_peak_core #(
   parameter int FRAME_MAX   = cacp_pkg::FRAME_MAX_DEF,
   parameter int SAMPLE_BITS = cacp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cacp_pkg::PEAK_W-1:0]   rsp_peak_value,
   output logic [cacp_pkg::LAG_W-1:0]           rsp_peak_lag,
   output logic [cacp_pkg::ZLC_W-1:0]           rsp_zero_lag_count,
   output logic signed [SAMPLE_BITS-1:0]        rsp_clip_level,
   input  logic                                 csr_wen,
   input  logic [cacp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cacp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import cacp_pkg::*;

   localparam int CNT_W  = $clog2(FRAME_MAX + 1);
   localparam int ADDR_W = $clog2(FRAME_MAX);

   logic [FRAME_LEN_W-1:0] frame_len_ff;
   logic [LAG_W-1:0]       min_lag_ff;
   logic [LAG_W-1:0]       max_lag_ff;
   logic [SCALE_W-1:0]     clip_scale_ff;

   logic [31:0]      len_raw;
   logic [CNT_W-1:0] frame_len;
   cfg_type          cfg;

   logic                   sram_we;
   logic [ADDR_W-1:0]      sram_waddr;
   logic [SAMPLE_BITS-1:0] sram_wdata;
   logic [ADDR_W-1:0]      sram_raddr;
   logic [SAMPLE_BITS-1:0] sram_rdata;
   logic                   cram_we;
   logic [ADDR_W-1:0]      cram_waddr;
   logic [1:0]             cram_wdata;
   logic [ADDR_W-1:0]      cram_raddr_a;
   logic [ADDR_W-1:0]      cram_raddr_b;
   logic [1:0]             cram_rdata_a;
   logic [1:0]             cram_rdata_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff  <= FRAME_LEN_RST;
         min_lag_ff    <= MIN_LAG_RST;
         max_lag_ff    <= MAX_LAG_RST;
         clip_scale_ff <= CLIP_SCALE_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH: frame_len_ff  <= csr_wdata[FRAME_LEN_W-1:0];
            CSR_MIN_LAG:      min_lag_ff    <= csr_wdata[LAG_W-1:0];
            CSR_MAX_LAG:      max_lag_ff    <= csr_wdata[LAG_W-1:0];
            CSR_CLIP_SCALE:   clip_scale_ff <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The frame length in use is clamped between FRAME_MIN and the depth the stores can hold.
   assign len_raw = 32'(frame_len_ff);

   always_comb begin
      priority if (len_raw < 32'(FRAME_MIN)) begin
         frame_len = CNT_W'(FRAME_MIN);
      end else if (len_raw > 32'(FRAME_MAX)) begin
         frame_len = CNT_W'(FRAME_MAX);
      end else begin
         frame_len = CNT_W'(len_raw);
      end
   end

   // A maximum lag below the minimum searches the minimum lag alone.
   assign cfg.lag_lo     = min_lag_ff;
   assign cfg.lag_hi     = (max_lag_ff < min_lag_ff) ? min_lag_ff : max_lag_ff;
   assign cfg.clip_scale = clip_scale_ff;

   cacp_sample_ram #(
      .DEPTH  (FRAME_MAX),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (sram_we),
      .wr_addr (sram_waddr),
      .wr_data (sram_wdata),
      .rd_addr (sram_raddr),
      .rd_data (sram_rdata)
   );

   cacp_clip_ram #(
      .DEPTH  (FRAME_MAX),
      .ADDR_W (ADDR_W)
   ) u_clip_ram (
      .clock     (clock),
      .wr_en     (cram_we),
      .wr_addr   (cram_waddr),
      .wr_data   (cram_wdata),
      .rd_addr_a (cram_raddr_a),
      .rd_addr_b (cram_raddr_b),
      .rd_data_a (cram_rdata_a),
      .rd_data_b (cram_rdata_b)
   );

   cacp_engine #(
      .FRAME_MAX   (FRAME_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .frame_len          (frame_len),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_peak_value     (rsp_peak_value),
      .rsp_peak_lag       (rsp_peak_lag),
      .rsp_zero_lag_count (rsp_zero_lag_count),
      .rsp_clip_level     (rsp_clip_level),
      .sram_we            (sram_we),
      .sram_waddr         (sram_waddr),
      .sram_wdata         (sram_wdata),
      .sram_raddr         (sram_raddr),
      .sram_rdata         (sram_rdata),
      .cram_we            (cram_we),
      .cram_waddr         (cram_waddr),
      .cram_wdata         (cram_wdata),
      .cram_raddr_a       (cram_raddr_a),
      .cram_raddr_b       (cram_raddr_b),
      .cram_rdata_a       (cram_rdata_a),
      .cram_rdata_b       (cram_rdata_b)
   );

endmodule
